@@ design/wss_pkg.sv @@
// Package for the windowed substring search block.
// Shared constants, register indexes, the result struct and the case-fold function.
// No dependencies.
package wss_pkg;

  localparam int MaxPattern = 8;
  localparam int PatIdxW    = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int LenW       = 4;
  localparam int PosW       = 15;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 64;

  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  localparam logic [CfgIdxW-1:0] RegPattern = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLength  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCase    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWinLo   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWinHi   = 3'd4;

  localparam logic [7:0] LowerA    = 8'd97;
  localparam logic [7:0] LowerZ    = 8'd122;
  localparam logic [7:0] CaseDelta = 8'd32;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] pos;
  } result_t;

  typedef struct packed {
    logic [LenW-1:0] len;     // effective pattern length, 1..MaxPattern
    logic [PosW-1:0] win_lo;
    logic [PosW-1:0] win_hi;  // 0 = string end
  } track_cfg_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold_en);
    if (fold_en && b >= LowerA && b <= LowerZ) begin
      return b - CaseDelta;
    end
    return b;
  endfunction

endpackage

@@ design/wss_cell.sv @@
// One cell of the byte chain: holds one recent byte and compares the byte
// entering it against its pattern byte. Depends on wss_pkg.
module wss_cell import wss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] pat_byte_i,
  input  logic       fold_i,
  input  logic       active_i,
  output logic [7:0] byte_o,
  output logic       hit_o
);

  logic [7:0] byte_q, byte_d;

  assign byte_d = shift_i ? byte_i : byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  // inactive cells lie past the pattern and always agree
  assign hit_o  = !active_i || (fold_byte(byte_i, fold_i) == fold_byte(pat_byte_i, fold_i));
  assign byte_o = byte_q;

endmodule

@@ design/wss_track.sv @@
// Position counter and first-hit tracking for the substring search.
// Builds the result for the item that closes a string. Depends on wss_pkg.
module wss_track import wss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       last_i,
  input  logic       match_i,
  input  track_cfg_t cfg_i,
  output result_t    res_o
);

  logic [PosW-1:0] cnt_q, cnt_d;
  logic            wh_q, wh_d, fb_q, fb_d;
  logic [PosW-1:0] whp_q, whp_d, fbp_q, fbp_d;

  logic            len_ok, end_ok, hit, win_ok, use_fb;
  logic [PosW-1:0] start_pos;
  logic            wh_n, fb_n;
  logic [PosW-1:0] whp_n, fbp_n;

  always_comb begin
    len_ok    = (cnt_q != PosMax) &&
                ((PosW+1)'(cnt_q) + (PosW+1)'(1) >= (PosW+1)'(cfg_i.len));
    end_ok    = (cfg_i.win_hi == '0) || (cnt_q <= cfg_i.win_hi);
    hit       = match_i && len_ok && end_ok;
    start_pos = cnt_q + PosW'(1) - PosW'(cfg_i.len);
    win_ok    = start_pos >= cfg_i.win_lo;

    fb_n  = fb_q || hit;
    fbp_n = fb_q ? fbp_q : start_pos;
    wh_n  = wh_q || (hit && win_ok);
    whp_n = wh_q ? whp_q : start_pos;

    use_fb = cfg_i.win_lo > cnt_q;
    res_o.found = use_fb ? fb_n : wh_n;
    res_o.pos   = !res_o.found ? '0 : (use_fb ? fbp_n : whp_n);
  end

  always_comb begin
    cnt_d = cnt_q;
    wh_d  = wh_q;
    whp_d = whp_q;
    fb_d  = fb_q;
    fbp_d = fbp_q;
    if (step_i) begin
      if (last_i) begin
        cnt_d = '0;
        wh_d  = 1'b0;
        whp_d = '0;
        fb_d  = 1'b0;
        fbp_d = '0;
      end else begin
        cnt_d = (cnt_q == PosMax) ? cnt_q : cnt_q + PosW'(1);
        wh_d  = wh_n;
        whp_d = wh_n ? whp_n : '0;
        fb_d  = fb_n;
        fbp_d = fb_n ? fbp_n : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wh_q  <= 1'b0;
      whp_q <= '0;
      fb_q  <= 1'b0;
      fbp_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      wh_q  <= wh_d;
      whp_q <= whp_d;
      fb_q  <= fb_d;
      fbp_q <= fbp_d;
    end
  end

endmodule

@@ design/windowed_substring_search_top.sv @@
// Top level of the windowed substring search: config registers, cell chain,
// hit tracker and output register. Depends on wss_pkg, wss_cell, wss_track.
//
// Channel   Dir  Handshake                 Contents
// s_axis    in   s_axis_tvalid/tready      tdata = char_byte, tlast = last_char
// m_axis    out  m_axis_tvalid/tready      tdata = {match_position, found}
// cfg       in   cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i (always ready)
//
// One byte per cycle while ready; the cell chain compares all pattern bytes in parallel.
// A result appears in the output register in the cycle after the byte with tlast is accepted.
// Input stalls only while a result sits in the output register and m_axis_tready is low.
// rst_ni clears the registers to their defaults and empties the chain and tracker.
module windowed_substring_search_top import wss_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] char_byte
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,   // [0] found, [15:1] match_position
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [CfgDataW-1:0] pattern_q;
  logic [LenW-1:0]     length_q;
  logic                case_q;
  logic [PosW-1:0]     win_lo_q, win_hi_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      length_q  <= LenW'(1);
      case_q    <= 1'b1;
      win_lo_q  <= '0;
      win_hi_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegPattern: pattern_q <= cfg_data_i;
        RegLength:  length_q  <= cfg_data_i[LenW-1:0];
        RegCase:    case_q    <= cfg_data_i[0];
        RegWinLo:   win_lo_q  <= cfg_data_i[PosW-1:0];
        RegWinHi:   win_hi_q  <= cfg_data_i[PosW-1:0];
        default: ;
      endcase
    end
  end

  // effective length: 0 reads as 1, long values saturate
  logic [LenW-1:0]    len_eff;
  logic [PatIdxW-1:0] len_m1;

  always_comb begin
    if (length_q == '0) begin
      len_eff = LenW'(1);
    end else if (length_q > LenW'(MaxPattern)) begin
      len_eff = LenW'(MaxPattern);
    end else begin
      len_eff = length_q;
    end
    len_m1 = PatIdxW'(len_eff - LenW'(1));
  end

  logic [7:0] pat_arr [MaxPattern];
  logic [7:0] chain   [MaxPattern];
  logic [MaxPattern-1:0] cell_hit;
  logic       in_acc;
  logic       out_valid_q, out_valid_d;
  result_t    out_res_q, out_res_d, res;
  track_cfg_t tcfg;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign chain[0]      = s_axis_tdata;

  // cell k compares the byte k places back; it checks pattern byte len-1-k
  for (genvar k = 0; k < MaxPattern; k++) begin : g_cell
    logic               active;
    logic [PatIdxW-1:0] pat_idx;

    assign pat_arr[k] = pattern_q[8*k +: 8];
    assign active     = (PatIdxW+1)'(k) <= (PatIdxW+1)'(len_m1);
    assign pat_idx    = len_m1 - PatIdxW'(k);

    if (k < MaxPattern - 1) begin : g_link
      wss_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .shift_i    (in_acc),
        .byte_i     (chain[k]),
        .pat_byte_i (pat_arr[pat_idx]),
        .fold_i     (!case_q),
        .active_i   (active),
        .byte_o     (chain[k+1]),
        .hit_o      (cell_hit[k])
      );
    end else begin : g_tail
      wss_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .shift_i    (in_acc),
        .byte_i     (chain[k]),
        .pat_byte_i (pat_arr[pat_idx]),
        .fold_i     (!case_q),
        .active_i   (active),
        .byte_o     (),
        .hit_o      (cell_hit[k])
      );
    end
  end

  assign tcfg.len    = len_eff;
  assign tcfg.win_lo = win_lo_q;
  assign tcfg.win_hi = win_hi_q;

  wss_track u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (in_acc),
    .last_i  (s_axis_tlast),
    .match_i (&cell_hit),
    .cfg_i   (tcfg),
    .res_o   (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (in_acc && s_axis_tlast) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_res_q.pos, out_res_q.found};

endmodule

@@ design/wss_checker.sv @@
// Port-level checker for windowed_substring_search_top, attached by bind.
// Watches the stream handshakes only; no package dependencies.
module wss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[15:1] == '0)
    else $error("miss with nonzero position");

  // each new result follows an accepted last byte
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
    else $error("result without closing item");

  // input only stalls behind a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without cause");

endmodule

bind windowed_substring_search_top wss_checker u_wss_checker (.*);

@@ tb/tb_windowed_substring_search_top.sv @@
// Testbench for windowed_substring_search_top: streams byte strings, writes the search
// registers between strings and checks every result against an in-bench predictor.
// Depends on wss_pkg and the design sources.
module tb_windowed_substring_search_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wss_pkg::*;

  localparam int CycleLimit = 3_000_000;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd5;  // first index past the register map

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } stream_byte_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;   // [7:0] char_byte
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;        // [0] found, [15:1] match_position
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  stream_byte_t byte_q[$];
  result_t      hit_q[$];
  stream_byte_t nxt;
  result_t      want;

  // register copies, reset values
  logic [CfgDataW-1:0] cfg_pat  = '0;
  logic [LenW-1:0]     cfg_len  = 4'd1;
  logic                cfg_case = 1'b1;
  logic [PosW-1:0]     cfg_wlo  = '0;
  logic [PosW-1:0]     cfg_whi  = '0;

  // scan state for the string in flight
  logic [7:0]      tail [MaxPattern] = '{default: 8'h00};
  logic [PosW-1:0] scan_pos = '0;
  logic            win_hit  = 1'b0;
  logic [PosW-1:0] win_at   = '0;
  logic            any_hit  = 1'b0;
  logic [PosW-1:0] any_at   = '0;

  logic quiet = 1'b0;
  int   src_gap = 0;
  int   sink_stall = 0;
  int   cycles = 0;
  int   n_err = 0;
  int   n_bytes = 0;
  int   n_strings = 0;
  int   n_found = 0;
  int   n_writes = 0;

  windowed_substring_search_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  task automatic report(input string what);
    n_err++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  function automatic logic [7:0] upcase(input logic [7:0] b);
    if (!cfg_case && b >= LowerA && b <= LowerZ) begin
      return b - CaseDelta;
    end
    return b;
  endfunction

  function automatic int eff_len();
    if (cfg_len == 0) begin
      return 1;
    end
    if (cfg_len > MaxPattern) begin
      return MaxPattern;
    end
    return int'(cfg_len);
  endfunction

  // Advances the scan by one accepted byte; the byte with last queues the string's result.
  function automatic void scan_byte(input logic [7:0] ch, input logic is_last);
    int      p;
    int      n;
    int      s;
    int      k;
    logic    hit;
    logic    use_any;
    result_t r;
    p = int'(scan_pos);
    n = eff_len();
    for (k = MaxPattern - 1; k > 0; k--) begin
      tail[k] = tail[k-1];
    end
    tail[0] = ch;
    if (p < int'(PosMax) && p + 1 >= n) begin
      s = p + 1 - n;
      hit = (cfg_whi == 0) || (p <= int'(cfg_whi));
      for (k = 0; k < n; k++) begin
        if (upcase(cfg_pat[8*k +: 8]) != upcase(tail[n-1-k])) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        if (!any_hit) begin
          any_hit = 1'b1;
          any_at  = PosW'(s);
        end
        if (!win_hit && s >= int'(cfg_wlo)) begin
          win_hit = 1'b1;
          win_at  = PosW'(s);
        end
      end
    end
    if (is_last) begin
      // a start past the final byte falls back to a search from position 0
      use_any = int'(cfg_wlo) > p;
      r.found = use_any ? any_hit : win_hit;
      r.pos   = !r.found ? '0 : (use_any ? any_at : win_at);
      hit_q.push_back(r);
      for (k = 0; k < MaxPattern; k++) begin
        tail[k] = 8'h00;
      end
      scan_pos = '0;
      win_hit  = 1'b0;
      win_at   = '0;
      any_hit  = 1'b0;
      any_at   = '0;
    end else if (p < int'(PosMax)) begin
      scan_pos = scan_pos + PosW'(1);
    end
  endfunction

  // byte source
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        scan_byte(s_axis_tdata, s_axis_tlast);
        n_bytes++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
          src_gap = $urandom_range(0, 8);
          s_axis_tvalid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          nxt = byte_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.ch;
          s_axis_tlast  <= nxt.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result sink and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_strings++;
        if (m_axis_tdata[0] === 1'b1) begin
          n_found++;
        end
        if (hit_q.size() == 0) begin
          report($sformatf("result %h with no string pending", m_axis_tdata));
        end else begin
          want = hit_q.pop_front();
          if (m_axis_tdata[0] !== want.found) begin
            report($sformatf("string %0d: found %b, expected %b",
                             n_strings, m_axis_tdata[0], want.found));
          end
          if (m_axis_tdata[15:1] !== want.pos) begin
            report($sformatf("string %0d: match_position %0d, expected %0d",
                             n_strings, m_axis_tdata[15:1], want.pos));
          end
        end
      end
      if (quiet) begin
        m_axis_tready <= 1'b1;
      end else if (sink_stall != 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        sink_stall = $urandom_range(0, 8);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, hit_q.size());
      $display("tb_windowed_substring_search_top: errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    n_writes++;
    case (idx)
      RegPattern: cfg_pat  = val;
      RegLength:  cfg_len  = val[LenW-1:0];
      RegCase:    cfg_case = val[0];
      RegWinLo:   cfg_wlo  = val[PosW-1:0];
      RegWinHi:   cfg_whi  = val[PosW-1:0];
      default: ;
    endcase
  endtask

  // half the narrow-field writes carry junk above the field, which the block must drop
  task automatic write_field(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] v,
                             input int w);
    logic [CfgDataW-1:0] junk;
    junk = {$urandom, $urandom};
    if (w < CfgDataW && $urandom_range(0, 1) == 1) begin
      v = (junk << w) | v;
    end
    write_reg(idx, v);
  endtask

  // waits until no byte is queued or offered and every expected result has been checked
  task automatic drain();
    while (byte_q.size() != 0 || s_axis_tvalid || hit_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void push_byte(input logic [7:0] ch, input logic last);
    byte_q.push_back('{ch: ch, last: last});
  endfunction

  function automatic void push_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) begin
      push_byte(s[k], k == s.len() - 1);
    end
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] b);
    logic [7:0] lo;
    lo = b | CaseDelta;
    if (lo >= LowerA && lo <= LowerZ && $urandom_range(0, 2) == 0) begin
      return b ^ CaseDelta;
    end
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    int r;
    int k;
    r = $urandom_range(0, 9);
    k = $urandom_range(0, MaxPattern - 1);
    if (r < 5) begin
      return flip_case(cfg_pat[8*k +: 8]);
    end
    if (r < 7) begin
      return flip_case(LowerA + 8'($urandom_range(0, 3)));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly few distinct letters, so that partial matches and overlaps are common
  function automatic logic [CfgDataW-1:0] rand_pattern();
    logic [CfgDataW-1:0] v;
    int                  k;
    for (k = 0; k < MaxPattern; k++) begin
      case ($urandom_range(0, 4))
        0, 1:    v[8*k +: 8] = LowerA + 8'($urandom_range(0, 2));
        2:       v[8*k +: 8] = LowerA - CaseDelta + 8'($urandom_range(0, 2));
        default: v[8*k +: 8] = 8'($urandom_range(0, 255));
      endcase
    end
    return v;
  endfunction

  function automatic logic [PosW-1:0] pick_window(input int span);
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return '0;
    end
    if (r < 8) begin
      return PosW'($urandom_range(0, span));
    end
    if (r == 8) begin
      return PosMax;
    end
    return PosW'($urandom_range(0, int'(PosMax)));
  endfunction

  function automatic void push_random_string(input int n);
    logic [7:0] text [$];
    int         n_pat;
    int         at;
    int         k;
    n_pat = eff_len();
    for (k = 0; k < n; k++) begin
      text.push_back(noise_byte());
    end
    if ($urandom_range(0, 2) != 0) begin
      repeat ($urandom_range(1, 2)) begin
        at = $urandom_range(0, n - 1);
        for (k = 0; k < n_pat && at + k < n; k++) begin
          text[at+k] = flip_case(cfg_pat[8*k +: 8]);
        end
        // sometimes spoil one byte to leave a partial match behind
        k = at + $urandom_range(0, n_pat - 1);
        if ($urandom_range(0, 4) == 0 && k < n) begin
          text[k] = text[k] ^ 8'($urandom_range(1, 255));
        end
      end
    end
    for (k = 0; k < n; k++) begin
      push_byte(text[k], k == n - 1);
    end
  endfunction

  task automatic randomize_regs();
    int r;
    logic [LenW-1:0] len;
    if ($urandom_range(0, 3) == 0) begin
      write_reg(RegUnused + CfgIdxW'($urandom_range(0, 2)), {$urandom, $urandom});
    end
    r = $urandom_range(0, 19);
    if (r == 0) begin
      len = '0;
    end else if (r == 1) begin
      len = LenW'($urandom_range(MaxPattern + 1, 15));
    end else begin
      len = LenW'($urandom_range(1, MaxPattern));
    end
    write_field(RegPattern, rand_pattern(), CfgDataW);
    write_field(RegLength, len, LenW);
    write_field(RegCase, $urandom_range(0, 1), 1);
    write_field(RegWinLo, pick_window(30), PosW);
    write_field(RegWinHi, pick_window(45), PosW);
  endtask

  task automatic run_phase(input int n_items);
    int sent;
    int n;
    int r;
    sent = 0;
    randomize_regs();
    while (sent < n_items) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        n = $urandom_range(1, 3);
      end else if (r < 8) begin
        n = $urandom_range(1, 20);
      end else begin
        n = $urandom_range(20, 60);
      end
      push_random_string(n);
      sent += n;
    end
    drain();
  endtask

  initial begin
    int k;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: one-byte pattern 00
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    drain();

    // "aB" folded, then exact: restart after the partial match at position 0
    write_reg(RegPattern, 64'h4261);
    write_reg(RegLength, 64'd2);
    write_reg(RegCase, 64'd0);
    push_text("aAb");
    push_text("a");
    drain();
    write_reg(RegCase, 64'd1);
    push_text("aAb");
    drain();

    // length zero behaves as one
    write_reg(RegLength, 64'hFFFF_FFFF_FFFF_FFF0);
    write_reg(RegCase, 64'd0);
    push_text("xA");
    drain();

    // length fifteen clamps to eight, pattern all ones
    write_reg(RegPattern, '1);
    write_reg(RegLength, 64'hF);
    write_reg(RegCase, 64'd1);
    for (k = 0; k < MaxPattern; k++) begin
      push_byte(8'hFF, k == MaxPattern - 1);
    end
    drain();

    // unmapped indexes, then start after end, then start past the string
    write_reg(RegUnused, '1);
    write_reg(RegUnused + CfgIdxW'(1), '1);
    write_reg(RegUnused + CfgIdxW'(2), '0);
    write_reg(RegPattern, 64'h41);
    write_reg(RegLength, 64'd1);
    write_reg(RegWinLo, 64'd2);
    write_reg(RegWinHi, 64'd1);
    push_text("AAAA");
    drain();
    write_reg(RegWinLo, '1);
    write_reg(RegWinHi, 64'd0);
    push_text("xA");
    drain();

    for (k = 0; k < 20; k++) begin
      if (k == 17) begin
        quiet = 1'b1;
      end
      run_phase(65);
    end

    $display("Checked %0d strings (%0d hits) over %0d bytes with %0d register writes,",
             n_strings, n_found, n_bytes, n_writes);
    $display("including case folding, window limits, clamped lengths and unmapped indexes.");
    if (n_err == 0) begin
      $display("tb_windowed_substring_search_top: clean");
    end else begin
      $display("tb_windowed_substring_search_top: errors");
    end
    $finish;
  end

endmodule
